### design/rectangle_atlas_packer_assert.svh
// Assertion macros for the rectangle atlas packer.
`ifndef RECTANGLE_ATLAS_PACKER_ASSERT_SVH
`define RECTANGLE_ATLAS_PACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define RAP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RAP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RAP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/rap_pkg.sv
// Shared types and constants for the rectangle atlas packer.
`timescale 1ns / 1ps
package rap_pkg;
    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int IDX_W   = 6;
    localparam int CRD_W   = 16;
    localparam int AREA_W  = 27;

    // One placed rectangle as held in a cell of the chain.
    typedef struct packed {
        logic             valid;
        logic [CRD_W-1:0] x0;
        logic [CRD_W-1:0] y0;
        logic [CRD_W-1:0] x1;
        logic [CRD_W-1:0] y1;
    } rap_box_t;

    // Probe travelling down the chain: the candidate rectangle and the first hit.
    typedef struct packed {
        logic             live;
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic [CRD_W-1:0] w;
        logic [CRD_W-1:0] h;
        logic             hit;
        logic [CRD_W-1:0] hit_x1;
        logic [CRD_W-1:0] hit_y1;
    } rap_probe_t;
endpackage

### design/rap_cell.sv
// One cell of the collision chain: holds a placed rectangle and checks the probe.
`timescale 1ns / 1ps
module rap_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                load,
    input  rap_pkg::rap_box_t   box_in,
    input  rap_pkg::rap_probe_t probe_in,
    output rap_pkg::rap_probe_t probe_out
);
    import rap_pkg::*;

    rap_box_t   box_reg;
    rap_probe_t probe_reg;
    rap_probe_t probe_next;
    logic       overlap;

    always_comb
    begin
        overlap = box_reg.valid &&
            !((probe_in.x + probe_in.w <= box_reg.x0) || (box_reg.x1 <= probe_in.x) ||
              (probe_in.y + probe_in.h <= box_reg.y0) || (box_reg.y1 <= probe_in.y));
        probe_next = probe_in;
        if (probe_in.live && !probe_in.hit && overlap)
        begin
            probe_next.hit    = 1'b1;
            probe_next.hit_x1 = box_reg.x1;
            probe_next.hit_y1 = box_reg.y1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.valid   <= 1'b0;
            probe_reg.live  <= 1'b0;
        end
        else
        begin
            if (clear)
                box_reg.valid <= 1'b0;
            else if (load)
                box_reg <= box_in;
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;
endmodule

### design/rap_chain.sv
// Row of collision cells; the probe walks one cell per cycle.
`timescale 1ns / 1ps
module rap_chain #(
    parameter int N = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 load,
    input  logic [$clog2(N)-1:0] load_sel,
    input  rap_pkg::rap_box_t    box_in,
    input  rap_pkg::rap_probe_t  probe_in,
    output rap_pkg::rap_probe_t  probe_out
);
    import rap_pkg::*;

    localparam int SW = $clog2(N);

    rap_probe_t link [N+1];

    assign link[0] = probe_in;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        rap_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (clear),
            .load      (load && (load_sel == SW'(i))),
            .box_in    (box_in),
            .probe_in  (link[i]),
            .probe_out (link[i+1])
        );
    end

    assign probe_out = link[N];
endmodule

### design/rectangle_atlas_packer.sv
// Top level of the rectangle atlas packer.
// Rectangles load one per beat on s_axis; the beat with tlast starts a run if
// any rectangle is stored. The run sorts by area with one pass of the store per
// output slot, then places rectangles by a first-fit scan in which every
// candidate position sends a probe through a chain of MAX_RECTS cells, one cell
// per cycle. Results then leave on m_axis, one beat per rectangle; the next beat
// is read from the store only after the last one is taken. Input is held off
// for the whole run.
`timescale 1ns / 1ps
module rectangle_atlas_packer #(
    parameter int MAX_RECTS = 64,
    parameter int MAX_SIDE  = 4096,
    parameter int GROW_STEP = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // rect_width[12:0], rect_height[25:13]
    input  logic        s_axis_tlast,   // last_rect
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // rect_index, pos_x, pos_y, atlas_side, status
    output logic        m_axis_tlast    // last_out
);
    import rap_pkg::*;

    localparam int AW = $clog2(MAX_RECTS);
    localparam int CW = $clog2(MAX_RECTS + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_SORT, S_SORT_NEXT, S_START, S_ROW, S_PROBE, S_WAIT,
        S_DONE, S_GROW, S_OUT_RD, S_OUT
    } state_t;

    state_t             state_reg;
    logic [7:0]         border_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      slot_reg;
    logic [CW-1:0]      scan_reg;
    logic [CW-1:0]      placed_reg;
    logic [AW-1:0]      best_reg;
    logic [AREA_W:0]    best_area_reg;
    logic [MAX_RECTS-1:0] taken_reg;
    logic [CRD_W-1:0]   side_reg;
    logic [CRD_W-1:0]   x_reg;
    logic [CRD_W-1:0]   y_reg;
    logic [CRD_W-1:0]   w_reg;
    logic [CRD_W-1:0]   h_reg;
    logic [CRD_W:0]     low_reg;
    logic               fail_reg;
    logic [CW-1:0]      out_k_reg;
    logic [AW-1:0]      rd_idx_reg;

    logic [DIM_W-1:0]   wmem [MAX_RECTS];
    logic [DIM_W-1:0]   hmem [MAX_RECTS];
    logic [AW-1:0]      omem [MAX_RECTS];
    logic [POS_W-1:0]   xmem [MAX_RECTS];
    logic [POS_W-1:0]   ymem [MAX_RECTS];
    logic [DIM_W-1:0]   w_rd_reg;
    logic [DIM_W-1:0]   h_rd_reg;
    logic [AW-1:0]      o_rd_reg;
    logic [POS_W-1:0]   x_rd_reg;
    logic [POS_W-1:0]   y_rd_reg;

    logic [DIM_W-1:0]   in_w;
    logic [DIM_W-1:0]   in_h;
    logic               in_fire;
    logic               out_fire;
    logic [AREA_W:0]    area;
    logic [CRD_W-1:0]   pw;
    logic [CRD_W-1:0]   ph;

    rap_probe_t         probe_in;
    rap_probe_t         probe_out;
    rap_box_t           box_in;
    logic               chain_clear;
    logic               chain_load;

    assign in_w      = s_axis_tdata[12:0];
    assign in_h      = s_axis_tdata[25:13];
    assign cfg_ready = (state_reg == S_LOAD);
    assign s_axis_tready = (state_reg == S_LOAD);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign area      = {1'b0, AREA_W'(w_rd_reg) * AREA_W'(h_rd_reg)} + (AREA_W+1)'(1);
    assign pw        = CRD_W'(w_rd_reg) + CRD_W'({border_reg, 1'b0});
    assign ph        = CRD_W'(h_rd_reg) + CRD_W'({border_reg, 1'b0});

    assign chain_clear = (state_reg == S_START) && (placed_reg == '0) && (slot_reg == '0);
    assign chain_load  = (state_reg == S_DONE);
    assign box_in.valid = 1'b1;
    assign box_in.x0 = x_reg;
    assign box_in.y0 = y_reg;
    assign box_in.x1 = x_reg + w_reg;
    assign box_in.y1 = y_reg + h_reg;

    always_comb
    begin
        probe_in        = '0;
        probe_in.live   = (state_reg == S_PROBE);
        probe_in.x      = x_reg;
        probe_in.y      = y_reg;
        probe_in.w      = w_reg;
        probe_in.h      = h_reg;
    end

    rap_chain #(.N(MAX_RECTS)) u_chain
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (chain_clear),
        .load      (chain_load),
        .load_sel  (placed_reg[AW-1:0]),
        .box_in    (box_in),
        .probe_in  (probe_in),
        .probe_out (probe_out)
    );

    // Store write and registered reads.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_w != '0 && in_h != '0 && count_reg < CW'(MAX_RECTS))
        begin
            wmem[count_reg[AW-1:0]] <= in_w;
            hmem[count_reg[AW-1:0]] <= in_h;
        end
        if (state_reg == S_SORT_NEXT)
            omem[slot_reg[AW-1:0]] <= best_reg;
        if (state_reg == S_DONE)
        begin
            xmem[placed_reg[AW-1:0]] <= x_reg[POS_W-1:0];
            ymem[placed_reg[AW-1:0]] <= y_reg[POS_W-1:0];
        end
        w_rd_reg <= wmem[rd_idx_reg];
        h_rd_reg <= hmem[rd_idx_reg];
        o_rd_reg <= omem[rd_idx_reg];
        x_rd_reg <= xmem[rd_idx_reg];
        y_rd_reg <= ymem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            border_reg    <= '0;
            count_reg     <= '0;
            n_reg         <= '0;
            slot_reg      <= '0;
            scan_reg      <= '0;
            placed_reg    <= '0;
            taken_reg     <= '0;
            side_reg      <= CRD_W'(GROW_STEP);
            fail_reg      <= 1'b0;
            out_k_reg     <= '0;
            rd_idx_reg    <= '0;
            m_axis_tvalid <= 1'b0;
            m_axis_tlast  <= 1'b0;
            m_axis_tdata  <= '0;
            best_reg      <= '0;
            best_area_reg <= '0;
            x_reg <= '0; y_reg <= '0; w_reg <= '0; h_reg <= '0; low_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (cfg_valid && cfg_ready)
                        border_reg <= cfg_data;
                    if (in_fire)
                    begin
                        logic [CW-1:0] cnt;
                        cnt = count_reg;
                        if (in_w != '0 && in_h != '0 && count_reg < CW'(MAX_RECTS))
                            cnt = count_reg + 1'b1;
                        count_reg <= cnt;
                        if (s_axis_tlast && cnt != '0)
                        begin
                            n_reg         <= cnt;
                            slot_reg      <= '0;
                            scan_reg      <= '0;
                            taken_reg     <= '0;
                            best_area_reg <= '0;
                            rd_idx_reg    <= '0;
                            side_reg      <= CRD_W'(GROW_STEP);
                            placed_reg    <= '0;
                            fail_reg      <= 1'b0;
                            state_reg     <= S_SORT;
                        end
                    end
                end
                // Reads are registered, so the entry checked while scan_reg is k is entry k-1.
                S_SORT:
                begin
                    if (scan_reg != '0)
                    begin
                        if (!taken_reg[scan_reg[AW-1:0] - 1'b1] && area > best_area_reg)
                        begin
                            best_area_reg <= area;
                            best_reg      <= scan_reg[AW-1:0] - 1'b1;
                        end
                    end
                    if (scan_reg == n_reg)
                        state_reg <= S_SORT_NEXT;
                    else
                    begin
                        rd_idx_reg <= scan_reg[AW-1:0] + 1'b1;
                        scan_reg   <= scan_reg + 1'b1;
                    end
                end
                S_SORT_NEXT:
                begin
                    taken_reg[best_reg] <= 1'b1;
                    best_area_reg       <= '0;
                    scan_reg            <= '0;
                    rd_idx_reg          <= '0;
                    if (slot_reg + 1'b1 == n_reg)
                    begin
                        slot_reg  <= '0;
                        state_reg <= S_START;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= S_SORT;
                    end
                end
                // Look up the rectangle to place: first its id, then its size.
                S_START:
                begin
                    if (slot_reg == CW'(4))
                    begin
                        w_reg <= pw;
                        h_reg <= ph;
                        x_reg <= '0;
                        y_reg <= '0;
                        low_reg <= '1;
                        slot_reg <= CW'(1);
                        if (pw > side_reg || ph > side_reg)
                            state_reg <= S_GROW;
                        else
                            state_reg <= S_ROW;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                        if (slot_reg == CW'(2))
                            rd_idx_reg <= o_rd_reg;
                        else
                            rd_idx_reg <= placed_reg[AW-1:0];
                    end
                end
                S_ROW:
                begin
                    if (y_reg + h_reg > side_reg)
                        state_reg <= S_GROW;
                    else if (x_reg + w_reg > side_reg)
                    begin
                        if (low_reg[CRD_W] || low_reg[CRD_W-1:0] <= y_reg)
                            state_reg <= S_GROW;
                        else
                        begin
                            y_reg   <= low_reg[CRD_W-1:0];
                            x_reg   <= '0;
                            low_reg <= '1;
                        end
                    end
                    else
                        state_reg <= S_PROBE;
                end
                S_PROBE:
                    state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (probe_out.live)
                    begin
                        if (probe_out.hit)
                        begin
                            x_reg <= probe_out.hit_x1;
                            if (low_reg > {1'b0, probe_out.hit_y1})
                                low_reg <= {1'b0, probe_out.hit_y1};
                            state_reg <= S_ROW;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    placed_reg <= placed_reg + 1'b1;
                    slot_reg   <= '0;
                    if (placed_reg + 1'b1 == n_reg)
                    begin
                        out_k_reg  <= '0;
                        rd_idx_reg <= '0;
                        state_reg  <= S_OUT_RD;
                    end
                    else
                        state_reg <= S_START;
                end
                S_GROW:
                begin
                    slot_reg <= '0;
                    if (32'(side_reg) + 32'(GROW_STEP) > 32'(MAX_SIDE))
                    begin
                        fail_reg   <= 1'b1;
                        out_k_reg  <= '0;
                        rd_idx_reg <= '0;
                        state_reg  <= S_OUT_RD;
                    end
                    else
                    begin
                        side_reg  <= side_reg + CRD_W'(GROW_STEP);
                        state_reg <= S_START;
                    end
                end
                S_OUT_RD:
                begin
                    slot_reg <= slot_reg + 1'b1;
                    if (slot_reg == CW'(1))
                    begin
                        logic ok;
                        ok = out_k_reg < placed_reg;
                        m_axis_tdata  <= 48'({!ok, side_reg[DIM_W-1:0],
                                              ok ? y_rd_reg : POS_W'(0),
                                              ok ? x_rd_reg : POS_W'(0),
                                              IDX_W'(o_rd_reg)});
                        m_axis_tlast  <= (out_k_reg + 1'b1 == n_reg);
                        m_axis_tvalid <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        m_axis_tvalid <= 1'b0;
                        slot_reg      <= '0;
                        if (out_k_reg + 1'b1 == n_reg)
                            state_reg <= S_LOAD;
                        else
                        begin
                            out_k_reg  <= out_k_reg + 1'b1;
                            rd_idx_reg <= AW'(out_k_reg + 1'b1);
                            state_reg  <= S_OUT_RD;
                        end
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

`include "rectangle_atlas_packer_assert.svh"

    `RAP_ASSERT_IMPL(a_no_load_in_run, clk, rst_n, state_reg != S_LOAD, !s_axis_tready)
    `RAP_ASSERT_IMPL(a_placed_le_n, clk, rst_n, state_reg != S_LOAD, placed_reg <= n_reg)
    `RAP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

### tb/tb_rectangle_atlas_packer.sv
// Self-checking testbench for the rectangle atlas packer with a built-in packing predictor.
`timescale 1ns / 1ps
module tb_rectangle_atlas_packer;
    import rap_pkg::*;

    localparam int MAX_RECTS = 64;
    localparam int MAX_SIDE  = 4096;
    localparam int GROW_STEP = 128;
    localparam int SETTLE    = 2000;

    typedef struct {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             last;
    } rect_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [DIM_W-1:0] side;
        logic             overflow;
        logic             last;
    } placement_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    rectangle_atlas_packer #(
        .MAX_RECTS(MAX_RECTS),
        .MAX_SIDE (MAX_SIDE),
        .GROW_STEP(GROW_STEP)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // Predictor state.
    int unsigned border_px;
    int unsigned stored_w [MAX_RECTS];
    int unsigned stored_h [MAX_RECTS];
    int unsigned area_order [MAX_RECTS];
    int unsigned at_x [MAX_RECTS];
    int unsigned at_y [MAX_RECTS];
    int unsigned stored_count;

    rect_item_t  rect_q[$];
    placement_t  placement_q[$];
    int          mismatches;
    int          gap_left;
    int          stall_left;
    bit          no_gaps;

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (60_000) #1_000_000;
        $display("tb_rectangle_atlas_packer: done, errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit fits_at(int unsigned t, int unsigned w, int unsigned h,
                                   int unsigned side, output int unsigned ox,
                                   output int unsigned oy);
        int unsigned x, y, low_edge, px, py, pw, ph;
        bit          hit;
        y = 0;
        if (w > side || h > side) return 0;
        while (y + h <= side)
        begin
            low_edge = 32'hFFFF_FFFF;
            x = 0;
            while (x + w <= side)
            begin
                hit = 0;
                for (int p = 0; p < t; p++)
                begin
                    px = at_x[p];
                    py = at_y[p];
                    pw = stored_w[area_order[p]] + 2 * border_px;
                    ph = stored_h[area_order[p]] + 2 * border_px;
                    if (!((x + w <= px) || (px + pw <= x) || (y + h <= py) || (py + ph <= y)))
                    begin
                        hit = 1;
                        x = px + pw;
                        if (low_edge > py + ph) low_edge = py + ph;
                        break;
                    end
                end
                if (!hit)
                begin
                    ox = x;
                    oy = y;
                    return 1;
                end
            end
            if (low_edge == 32'hFFFF_FFFF || low_edge <= y) return 0;
            y = low_edge;
        end
        return 0;
    endfunction

    // Packs the stored rectangles as far as the atlas allows and queues one placement per rectangle.
    function automatic void pack_stored();
        int unsigned n, placed, side, best, best_area, a, id, x, y;
        bit          taken [MAX_RECTS];
        placement_t  pl;
        n = stored_count;
        if (n == 0) return;
        foreach (taken[k]) taken[k] = 0;
        for (int s = 0; s < n; s++)
        begin
            best = 0;
            best_area = 0;
            for (int k = 0; k < n; k++)
            begin
                a = 1 + stored_w[k] * stored_h[k];
                if (!taken[k] && a > best_area)
                begin
                    best_area = a;
                    best = k;
                end
            end
            taken[best] = 1;
            area_order[s] = best;
        end
        placed = 0;
        side = GROW_STEP;
        while (placed < n)
        begin
            id = area_order[placed];
            if (fits_at(placed, stored_w[id] + 2 * border_px, stored_h[id] + 2 * border_px,
                        side, x, y))
            begin
                at_x[placed] = x;
                at_y[placed] = y;
                placed++;
            end
            else if (side + GROW_STEP > MAX_SIDE)
                break;
            else
                side += GROW_STEP;
        end
        for (int k = 0; k < n; k++)
        begin
            pl.index    = IDX_W'(area_order[k]);
            pl.x        = (k < placed) ? POS_W'(at_x[k]) : POS_W'(0);
            pl.y        = (k < placed) ? POS_W'(at_y[k]) : POS_W'(0);
            pl.side     = DIM_W'(side);
            pl.overflow = (k >= placed);
            pl.last     = (k + 1 == n);
            placement_q = {placement_q, pl};
        end
    endfunction

    // Queues a rectangle for the driver and predicts what it causes.
    task automatic send_rect(int unsigned w, int unsigned h, bit last);
        rect_item_t it;
        it.width  = DIM_W'(w);
        it.height = DIM_W'(h);
        it.last   = last;
        rect_q = {rect_q, it};
        if (w != 0 && h != 0 && stored_count < MAX_RECTS)
        begin
            stored_w[stored_count] = w;
            stored_h[stored_count] = h;
            stored_count++;
        end
        if (last) pack_stored();
    endtask

    task automatic wait_idle();
        while (rect_q.size() != 0 || s_axis_tvalid || placement_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_border(int unsigned b);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= 8'(b);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        border_px = b;
    endtask

    task automatic random_phase(int unsigned b, int items);
        int unsigned w, h, r;
        bit          last;
        write_border(b);
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                // Zero-sized rectangle: dropped, but its bits still wiggle.
                w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 8191);
                h = (w == 0) ? $urandom_range(0, 8191) : 0;
            end
            else if (r < 8)
            begin
                w = $urandom_range(1, 1024);
                h = $urandom_range(1, 256);
            end
            else
            begin
                w = $urandom_range(1, 24);
                h = $urandom_range(1, 24);
            end
            last = (i == items - 1) ||
                   ($urandom_range(0, (stored_count < MAX_RECTS) ? 11 : 59) == 0);
            send_rect(w, h, last);
        end
    endtask

    initial
    begin
        border_px = 0;
        stored_count = 0;
        mismatches = 0;
        no_gaps = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_border(0);

        // Empty run, zero sizes with every low bit set, the full-width strip,
        // an area tie, and a rectangle taller than the starting atlas.
        send_rect(0, 4096, 1);
        send_rect(4095, 0, 0);
        send_rect(0, 4095, 0);
        send_rect(4096, 1, 0);
        send_rect(1, 1, 1);
        send_rect(5, 7, 0);
        send_rect(7, 5, 0);
        send_rect(3, 3, 1);
        send_rect(1, 300, 1);
        send_rect(0, 0, 1);

        random_phase(3, 70);
        random_phase(255, 30);
        random_phase($urandom_range(4, 254), 60);
        random_phase(1, 60);
        random_phase(0, 100);
        random_phase($urandom_range(0, 8), 90);

        wait_idle();
        if (mismatches == 0)
            $display("tb_rectangle_atlas_packer: done, clean");
        else
            $display("tb_rectangle_atlas_packer: done, errors");
        $finish;
    end

    // Input driver.
    always @(posedge clk or negedge rst_n)
    begin
        rect_item_t it;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (rect_q.size() != 0)
            begin
                it = rect_q.pop_front();
                s_axis_tdata  <= {6'd0, it.height, it.width};
                s_axis_tlast  <= it.last;
                s_axis_tvalid <= 1'b1;
                gap_left <= no_gaps ? 0 : pick_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        placement_t got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.index    = m_axis_tdata[5:0];
                got.x        = m_axis_tdata[17:6];
                got.y        = m_axis_tdata[29:18];
                got.side     = m_axis_tdata[42:30];
                got.overflow = m_axis_tdata[43];
                got.last     = m_axis_tlast;
                if (placement_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected placement beat: %p", got);
                end
                else
                begin
                    want = placement_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("placement mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left <= no_gaps ? 0 : pick_gap();
            end
        end
    end
endmodule
